// ===== rtl/core/sit_pkg.sv =====
// sit_pkg: shared widths, codes and controller/datapath interface types
// for the sorted insertion table core
// no dependencies
package sit_pkg;

  // default sizes
  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_BYTES = 8;

  // word field widths
  localparam int FUNC_W     = 2;
  localparam int KEY_FLD_W  = 64;
  localparam int ID_W       = 32;
  localparam int RIDX_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 5;
  localparam int CNT_FLD_W  = 5;

  // packed bus widths, rounded up to whole bytes
  localparam int S_TDATA_W = ((KEY_FLD_W + ID_W + RIDX_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((POS_W + KEY_FLD_W + ID_W + CNT_FLD_W + 7) / 8) * 8;
  localparam int S_PAD_W   = S_TDATA_W - (KEY_FLD_W + ID_W + RIDX_W);
  localparam int M_PAD_W   = M_TDATA_W - (POS_W + KEY_FLD_W + ID_W + CNT_FLD_W);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd2;

  typedef enum logic [2:0] {
    RES_INSERT,
    RES_FULL,
    RES_READ,
    RES_BAD_INDEX,
    RES_NONE
  } res_kind_t;

  typedef enum logic {
    POS_ABOVE,
    POS_SLOT
  } pos_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      rd_first;
    logic      rd_inc;
    logic      rd_init;
    logic      rd_dec;
    logic      rd_ridx;
    logic      slot_load;
    logic      wr_shift;
    logic      wr_new;
    pos_sel_t  pos_sel;
    logic      res_load;
    res_kind_t res_kind;
    logic      cnt_inc;
    logic      cnt_clear;
  } sit_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              full;
    logic              empty;
    logic              ridx_ok;
    logic              move;
    logic              ptr_last;
    logic              at_slot;
    logic              out_free;
  } sit_stat_t;

endpackage

// ===== rtl/core/sit_datapath.sv =====
// sit_datapath: entry memory, count, scan pointer, key compare and
// output word register of the sorted insertion table
// depends on sit_pkg
module sit_datapath import sit_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [FUNC_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]  m_tuser,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_wr_data,
  input  sit_cmd_t             cmd,
  output sit_stat_t            stat
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int ENT_W = KEY_W + ID_W;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RC_W  = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  // zero every byte after the first zero byte, as a string compare sees it
  function automatic logic [KEY_W-1:0] canon(input logic [KEY_W-1:0] k);
    logic             seen_zero;
    logic [KEY_W-1:0] r;
    seen_zero = 1'b0;
    r = k;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      if (seen_zero) begin
        r[b*8 +: 8] = 8'd0;
      end else if (k[b*8 +: 8] == 8'd0) begin
        seen_zero = 1'b1;
      end
    end
    return r;
  endfunction

  logic [ENT_W-1:0]    mem [CAPACITY];
  logic [ENT_W-1:0]    rdata;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [ENT_W-1:0]    wdata;
  logic                wr_en;

  logic [FUNC_W-1:0]   op;
  logic [KEY_W-1:0]    key;
  logic [KEY_W-1:0]    ckey;
  logic [ID_W-1:0]     id;
  logic [RIDX_W-1:0]   ridx;
  logic [IDX_W-1:0]    ptr;
  logic [IDX_W-1:0]    slot;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                sort_order;
  logic                out_valid;

  logic [STATUS_W-1:0]  res_status;
  logic [POS_W-1:0]     res_pos;
  logic [KEY_FLD_W-1:0] res_key;
  logic [ID_W-1:0]      res_id;
  logic [CNT_FLD_W-1:0] res_cnt;

  logic [KEY_W-1:0]    skey;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_first || cmd.rd_inc || cmd.rd_init || cmd.rd_dec || cmd.rd_ridx) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    priority if (cmd.rd_init) begin
      raddr = IDX_W'(count - CNT_W'(1));
    end else if (cmd.rd_dec) begin
      raddr = ptr - IDX_W'(1);
    end else if (cmd.rd_first) begin
      raddr = '0;
    end else if (cmd.rd_inc) begin
      raddr = ptr + IDX_W'(1);
    end else begin
      raddr = IDX_W'(ridx);
    end
  end

  assign wr_en = cmd.wr_shift || cmd.wr_new;
  assign waddr = (cmd.wr_new && cmd.pos_sel == POS_SLOT) ? slot : ptr + IDX_W'(1);
  assign wdata = cmd.wr_shift ? rdata : {id, key};

  // stored entry sorts after the new key: the new entry goes in front of it
  assign skey = canon(rdata[KEY_W-1:0]);

  always_comb begin
    count_next = count;
    if (cmd.cnt_clear) begin
      count_next = '0;
    end else if (cmd.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op   <= s_tuser;
      key  <= s_tdata[KEY_W-1:0];
      ckey <= canon(s_tdata[KEY_W-1:0]);
      id   <= s_tdata[KEY_FLD_W +: ID_W];
      ridx <= s_tdata[KEY_FLD_W + ID_W +: RIDX_W];
      slot <= '0;
    end else if (cmd.slot_load) begin
      slot <= ptr;
    end
    if (cmd.rd_init) begin
      ptr <= IDX_W'(count - CNT_W'(1));
    end else if (cmd.rd_dec) begin
      ptr <= ptr - IDX_W'(1);
    end else if (cmd.rd_first) begin
      ptr <= '0;
    end else if (cmd.rd_inc) begin
      ptr <= ptr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sort_order <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_wr_en) begin
        sort_order <= cfg_wr_data[0];
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_cnt <= CNT_FLD_W'(count_next);
      unique case (cmd.res_kind)
        RES_INSERT: begin
          res_status <= STAT_DONE;
          res_pos    <= POS_W'(waddr);
          res_key    <= KEY_FLD_W'(key);
          res_id     <= id;
        end
        RES_FULL: begin
          res_status <= STAT_FULL;
          res_pos    <= '0;
          res_key    <= '0;
          res_id     <= '0;
        end
        RES_READ: begin
          res_status <= STAT_DONE;
          res_pos    <= POS_W'(ridx);
          res_key    <= KEY_FLD_W'(rdata[KEY_W-1:0]);
          res_id     <= rdata[KEY_W +: ID_W];
        end
        RES_BAD_INDEX: begin
          res_status <= STAT_BAD_INDEX;
          res_pos    <= POS_W'(ridx);
          res_key    <= '0;
          res_id     <= '0;
        end
        default: begin
          res_status <= STAT_DONE;
          res_pos    <= '0;
          res_key    <= '0;
          res_id     <= '0;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {{M_PAD_W{1'b0}}, res_cnt, res_id, res_key, res_pos};

  assign stat.op       = op;
  assign stat.full     = (count == CNT_W'(CAPACITY));
  assign stat.empty    = (count == '0);
  assign stat.ridx_ok  = (RC_W'(ridx) < RC_W'(count));
  assign stat.move     = sort_order ? (ckey > skey) : (ckey < skey);
  assign stat.ptr_last = (ptr == IDX_W'(count - CNT_W'(1)));
  assign stat.at_slot  = (ptr == slot);
  assign stat.out_free = !out_valid || m_tready;

endmodule

// ===== rtl/core/sit_ctrl.sv =====
// sit_ctrl: operation sequencer of the sorted insertion table
// drives sit_datapath through sit_cmd_t, reads back sit_stat_t
// depends on sit_pkg
module sit_ctrl import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  sit_stat_t stat,
  output sit_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_PLACE    = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_SEARCH   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          FUNC_INSERT: begin
            if (stat.full) begin
              if (stat.out_free) begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_FULL;
                state_next   = S_IDLE;
              end
            end else if (stat.empty) begin
              if (stat.out_free) begin
                cmd.wr_new   = 1'b1;
                cmd.pos_sel  = POS_SLOT;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_INSERT;
                cmd.cnt_inc  = 1'b1;
                state_next   = S_IDLE;
              end
            end else begin
              cmd.rd_first = 1'b1;
              state_next   = S_SEARCH;
            end
          end
          FUNC_READ: begin
            if (stat.ridx_ok) begin
              cmd.rd_ridx = 1'b1;
              state_next  = S_READ;
            end else if (stat.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_BAD_INDEX;
              state_next   = S_IDLE;
            end
          end
          FUNC_CLEAR: begin
            if (stat.out_free) begin
              cmd.res_load  = 1'b1;
              cmd.res_kind  = RES_NONE;
              cmd.cnt_clear = 1'b1;
              state_next    = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_NONE;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      // walk up from entry 0 to the first entry that sorts after the key
      S_SEARCH: begin
        if (stat.move) begin
          cmd.slot_load = 1'b1;
          cmd.rd_init   = 1'b1;
          state_next    = S_SCAN;
        end else if (!stat.ptr_last) begin
          cmd.rd_inc = 1'b1;
        end else if (stat.out_free) begin
          cmd.wr_new   = 1'b1;
          cmd.pos_sel  = POS_ABOVE;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_INSERT;
          cmd.cnt_inc  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // move entries from the top down to the slot up by one
      S_SCAN: begin
        cmd.wr_shift = 1'b1;
        if (stat.at_slot) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_dec = 1'b1;
        end
      end
      S_PLACE: begin
        if (stat.out_free) begin
          cmd.wr_new   = 1'b1;
          cmd.pos_sel  = POS_SLOT;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_INSERT;
          cmd.cnt_inc  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_READ;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sorted_insertion_table_core.sv =====
// output word register loads from dispatch, once the output is free, for clear, full-table
// insert, out-of-range read, unused codes and insert into an empty table; reads load from S_READ
// insert: search up from entry 0 one entry a cycle; an append at the end loads from the search,
// else search, then entries at and above the slot move up one a cycle, then place
// one word in flight: next word taken the cycle after the result loads; a held result delays it
// reset (rst, synchronous) empties the table, sets ascending order, drops the output word
module sorted_insertion_table_core import sit_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,   // entries held, 2 to 31
  parameter int KEY_BYTES = DEF_KEY_BYTES   // key bytes compared and stored, 1 to 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // input words
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,     // new_key[63:0], new_id[95:64], read_index[99:96]
  input  logic [FUNC_W-1:0]    s_tuser,     // func[1:0]
  // result words
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,     // position[4:0], out_key[68:5], out_id[100:69],
                                            // entry_count[105:101]
  output logic [STATUS_W-1:0]  m_tuser,     // status[1:0]
  // sort_order register, to be written only while idle; the core does not enforce it
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_wr_data  // sort_order: 0 ascending, 1 descending
);

  sit_cmd_t  cmd;
  sit_stat_t stat;

  // sequencer: dispatch on the operation, search for the slot, then shift from the top down
  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry memory, count, compare against the captured key, output word register
  sit_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== rtl/core/sit_checker.sv =====
// sit_port_checks: port-level checks of the sorted insertion table core
// bound to sorted_insertion_table_core; depends on sit_pkg
module sit_port_checks import sit_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]  m_tuser
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // reset drops any pending result
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a full-table reject reports a full count and empty payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STAT_FULL |->
      m_tdata[105:101] == CNT_FLD_W'(CAPACITY) && m_tdata[100:0] == '0)
    else $error("full status with wrong count or payload");

  // an out-of-range read returns no entry and an index at or beyond the count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STAT_BAD_INDEX |->
      m_tdata[100:5] == '0 && m_tdata[4:0] >= m_tdata[105:101])
    else $error("bad index status with entry data");

  // the table never reports more entries than it holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[105:101]) <= 32'(CAPACITY))
    else $error("entry count beyond capacity");

endmodule

bind sorted_insertion_table_core sit_port_checks #(
  .CAPACITY (CAPACITY)
) u_port_checks (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/sit_checker.sv =====
// sit_checker: watches the word channels and register writes of the sorted insertion table,
// predicts every result word and compares it field by field
// depends on sit_pkg for widths, operation and status codes
module sit_checker import sit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [FUNC_W-1:0]    s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic [STATUS_W-1:0]  m_tuser,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_wr_data,
  output int                   mismatch_count,
  output int                   results_owed
);

  localparam int HIDX_W = $clog2(DEF_CAPACITY);

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [KEY_FLD_W-1:0] key;
    logic [ID_W-1:0]      id;
    logic [CNT_FLD_W-1:0] count;
  } table_result_t;

  logic [KEY_FLD_W-1:0] keys_held [DEF_CAPACITY];
  logic [ID_W-1:0]      ids_held  [DEF_CAPACITY];
  int                   held;
  bit                   descending;
  int                   fail_tally;
  table_result_t        owed_q [$];

  // strcmp view of a key: bytes after the first zero byte do not count
  function automatic logic [KEY_FLD_W-1:0] strcmp_view(logic [KEY_FLD_W-1:0] k);
    logic [KEY_FLD_W-1:0] r;
    bit                   ended;
    r     = k;
    ended = 0;
    for (int b = DEF_KEY_BYTES - 1; b >= 0; b--) begin
      if (ended) r[b*8 +: 8] = 8'h00;
      else if (k[b*8 +: 8] == 8'h00) ended = 1;
    end
    return r;
  endfunction

  // applies one word to the table copy and returns the result word it should give
  function automatic table_result_t apply_word(logic [FUNC_W-1:0] op, logic [KEY_FLD_W-1:0] key,
                                               logic [ID_W-1:0] id, logic [RIDX_W-1:0] idx);
    table_result_t        r;
    int                   slot;
    logic [KEY_FLD_W-1:0] nk;
    logic [KEY_FLD_W-1:0] sk;
    r.status   = STAT_DONE;
    r.position = '0;
    r.key      = '0;
    r.id       = '0;
    case (op)
      FUNC_INSERT: begin
        if (held >= DEF_CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          nk   = strcmp_view(key);
          slot = held;
          // scan downward so the first entry that sorts after the key wins
          for (int i = held - 1; i >= 0; i--) begin
            sk = strcmp_view(keys_held[HIDX_W'(i)]);
            if (descending ? (nk > sk) : (nk < sk)) slot = i;
          end
          for (int j = held; j > slot; j--) begin
            keys_held[HIDX_W'(j)] = keys_held[HIDX_W'(j-1)];
            ids_held[HIDX_W'(j)]  = ids_held[HIDX_W'(j-1)];
          end
          keys_held[HIDX_W'(slot)] = key;
          ids_held[HIDX_W'(slot)]  = id;
          held++;
          r.position = POS_W'(slot);
          r.key      = key;
          r.id       = id;
        end
      end
      FUNC_READ: begin
        r.position = POS_W'(idx);
        if (idx >= held) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          r.key = keys_held[idx];
          r.id  = ids_held[idx];
        end
      end
      FUNC_CLEAR: held = 0;
      default: ;
    endcase
    r.count = CNT_FLD_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t exp;
    if (rst) begin
      owed_q.delete();
      held           = 0;
      descending     = 0;
      fail_tally     = 0;
      mismatch_count <= 0;
      results_owed   <= 0;
    end else begin
      if (cfg_wr_en) descending = cfg_wr_data[0];
      // result side first, so a word never meets the expectation pushed at the same edge
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          $error("result word with nothing owed: status %0d position %0d", m_tuser,
                 m_tdata[4:0]);
          fail_tally++;
        end else begin
          exp = owed_q.pop_front();
          if (m_tuser !== exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp.status, m_tuser);
            fail_tally++;
          end
          if (m_tdata[4:0] !== exp.position) begin
            $error("position mismatch: expected %0d, actual %0d", exp.position, m_tdata[4:0]);
            fail_tally++;
          end
          if (m_tdata[68:5] !== exp.key) begin
            $error("out_key mismatch: expected %h, actual %h", exp.key, m_tdata[68:5]);
            fail_tally++;
          end
          if (m_tdata[100:69] !== exp.id) begin
            $error("out_id mismatch: expected %0d, actual %0d", $signed(exp.id),
                   $signed(m_tdata[100:69]));
            fail_tally++;
          end
          if (m_tdata[105:101] !== exp.count) begin
            $error("entry_count mismatch: expected %0d, actual %0d", exp.count,
                   m_tdata[105:101]);
            fail_tally++;
          end
        end
      end
      if (s_tvalid && s_tready)
        owed_q.push_back(apply_word(s_tuser, s_tdata[63:0], s_tdata[95:64], s_tdata[99:96]));
      mismatch_count <= fail_tally;
      results_owed   <= owed_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// testbench: drives the sorted insertion table core with directed and random words
// under several idling patterns; sit_checker predicts and compares the results
// depends on sit_pkg, sorted_insertion_table_core and sit_checker
module testbench;
  import sit_pkg::*;

  // the one func code the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // sort_order register values
  localparam logic ORDER_ASC  = 1'b0;
  localparam logic ORDER_DESC = 1'b1;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 cfg_wr_en = 1'b0;
  logic [0:0]           cfg_wr_data = '0;

  int mismatch_count;
  int results_owed;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_served = 0;
  int hold_left = 0;

  // small pool of keys so equal keys show up often; even entries carry a zero
  // byte in the middle so random tails below it compare equal
  logic [KEY_FLD_W-1:0] key_pool [8];

  always #6 clk = ~clk;

  sorted_insertion_table_core DUT (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sit_checker table_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (holds_served != hold_reqs) begin
      holds_served = holds_served + 1;
      hold_left    = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offers one word, with a random gap first, and returns at the accepting edge
  task automatic send_word(logic [FUNC_W-1:0] op, logic [KEY_FLD_W-1:0] key,
                           logic [ID_W-1:0] id, logic [RIDX_W-1:0] idx);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{S_PAD_W{1'b0}}, idx, id, key};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait until every owed result is back, then let the core settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called while the core is idle
  task automatic write_order(logic order);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // key mix: extremes, pooled repeats, equal heads with random tails,
  // embedded zero bytes, short keys and plain random ones
  function automatic logic [KEY_FLD_W-1:0] pick_key();
    logic [KEY_FLD_W-1:0] k;
    int                   b;
    k = {$urandom, $urandom};
    b = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0: k = '0;
      1: k = '1;
      2: k = key_pool[3'($urandom_range(0, 7))];
      3: k[63:24] = key_pool[3'($urandom_range(0, 7))][63:24];
      4, 5: k[b*8 +: 8] = 8'h00;
      6: k = (k >> (8 * b)) << (8 * b);
      default: ;
    endcase
    return k;
  endfunction

  // one random word: mostly inserts and reads, with a clear now and then so the
  // table both fills up and empties
  task automatic send_random();
    int                pick;
    logic [FUNC_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 60) op = FUNC_INSERT;
    else if (pick < 93) op = FUNC_READ;
    else if (pick < 97) op = FUNC_CLEAR;
    else op = FUNC_UNUSED;
    if ($urandom_range(0, 49) == 0) key_pool[3'($urandom_range(0, 7))] = {$urandom, $urandom};
    send_word(op, pick_key(), $urandom, RIDX_W'($urandom_range(0, 15)));
  endtask

  task automatic run_phase(int words, int idle, int stall, logic order, bit with_hold,
                           bit with_pause);
    drain();
    write_order(order);
    send_idle_pct = idle;
    stall_pct <= stall;
    for (int n = 0; n < words; n++) begin
      // long receiver hold-off while words keep coming: the core backs up
      if (with_hold && n == words / 4) hold_reqs <= hold_reqs + 1;
      // sender waits for every result before going on
      if (with_pause && n == words / 2) drain();
      send_random();
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      key_pool[3'(i)] = {$urandom, $urandom};
      if (i % 2 == 0) key_pool[3'(i)][31:24] = 8'h00;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, ascending order
    drain();
    write_order(ORDER_ASC);
    send_word(FUNC_INSERT, 64'h0, 32'h0, 4'd0);
    send_word(FUNC_INSERT, '1, 32'hFFFF_FFFF, 4'd0);
    // zero byte in the middle: the bytes after it are stored but do not compare
    send_word(FUNC_INSERT, 64'h4142_0055_6677_8899, 32'h8000_0000, 4'd0);
    // equal under strcmp, so these land after the one above
    send_word(FUNC_INSERT, 64'h4142_00AA_BBCC_DDEE, 32'h7FFF_FFFF, 4'd0);
    send_word(FUNC_INSERT, 64'h4142_0000_0000_0000, 32'd5, 4'd0);
    send_word(FUNC_READ, 64'h0, 32'h0, 4'd2);
    // read beyond the entry count
    send_word(FUNC_READ, 64'h0, 32'h0, 4'd15);
    send_word(FUNC_UNUSED, '1, 32'hFFFF_FFFF, 4'd15);
    // fill the table, then one insert too many
    repeat (11) send_word(FUNC_INSERT, pick_key(), $urandom, 4'd0);
    send_word(FUNC_INSERT, 64'h1234_5678_9ABC_DEF0, 32'd1, 4'd0);
    send_word(FUNC_READ, 64'h0, 32'h0, 4'd15);
    send_word(FUNC_READ, 64'h0, 32'h0, 4'd0);
    send_word(FUNC_CLEAR, 64'h0, 32'h0, 4'd0);
    send_word(FUNC_READ, 64'h0, 32'h0, 4'd0);

    // descending order, including an equal key
    drain();
    write_order(ORDER_DESC);
    send_word(FUNC_INSERT, 64'h0100_0000_0000_0000, 32'd10, 4'd0);
    send_word(FUNC_INSERT, 64'hFF00_0000_0000_0000, 32'd11, 4'd0);
    send_word(FUNC_INSERT, 64'h0100_0012_3456_789A, 32'd12, 4'd0);

    // random part: each idling pattern with both orders
    run_phase(200, 0, 0, ORDER_DESC, 1, 0);
    run_phase(200, 71, 0, ORDER_ASC, 0, 1);
    run_phase(200, 0, 71, ORDER_DESC, 0, 0);
    run_phase(200, 11, 11, ORDER_ASC, 0, 0);
    run_phase(200, 0, 0, ORDER_ASC, 0, 1);
    run_phase(200, 71, 0, ORDER_DESC, 0, 0);
    run_phase(200, 0, 71, ORDER_ASC, 1, 0);
    run_phase(200, 11, 11, ORDER_DESC, 0, 0);

    // wait out every owed result, then a few more cycles for stray words
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
